@@ rtl/hcr_pkg.sv @@
// ----------------------------------------------------------------------------
// hcr_pkg
// shared types and constants of the cubic resampler
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int STORE_DEPTH  = 16384;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int FRAME_W      = ADDR_W + 1;
  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int CC_W         = 4;
  localparam int RATIO_W      = 21;
  localparam int TOT_W        = 19;
  localparam int NUM_W        = TOT_W + FRAME_W;
  localparam int DIV_W        = NUM_W + 16;
  localparam int CNT_W        = $clog2(DIV_W);
  localparam int ACC_W        = 40;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PULL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_B = 2'd0,
    SEL_A = 2'd1,
    SEL_C = 2'd2,
    SEL_D = 2'd3
  } nb_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TOT, S_LATCH, S_CHK, S_DIV, S_RB, S_RA, S_RC, S_RD, S_RW,
    S_K, S_MUL, S_ADD, S_OUT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       prod_ld;
    logic       latch_total;
    logic       chk;
    logic       div_step;
    logic       rd_en;
    nb_sel_t    rd_sel;
    logic       cap_en;
    nb_sel_t    cap_sel;
    logic       k_ld;
    logic       mul;
    logic       add;
    logic [1:0] add_sel;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic out_free;
  } status_t;

endpackage

@@ rtl/hermite_cubic_resampler.sv @@
// ----------------------------------------------------------------------------
// hermite_cubic_resampler
// four-point cubic resampler of a loaded block of interleaved Q1.15 samples
// ----------------------------------------------------------------------------
// input words carry an operation: load appends in_sample to the block
// until the first pull after a clear or reset and while the store has
// room, clear empties it, pull asks for the next output sample. loads and
// clears give no output word. a pull gives one output word (out_sample,
// out_block_last) after these steps: the output length, the bit-serial
// 50-bit position divider, the four neighbour reads through the single
// store read port, and the three multiply-add steps of the cubic, and last
// the result. a pull on an empty or finished block skips the divider and
// the cubic and gives its zero word. one word is worked at a time;
// in_stall is high while a pull is in progress.
// the result sits in an output register: when out_stall holds it, the next
// word is still taken and a following pull waits only at its final step.
// cfg words (cfg_index 0 channel count, 1 rate ratio) are always ready;
// the user must write them only while the block is idle (not enforced).
// reset empties the block and sets 2 channels and ratio 1.0; the store
// keeps no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module hermite_cubic_resampler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic signed [15:0]          in_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_sample,
  output logic                        out_block_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [hcr_pkg::RATIO_W-1:0] cfg_wdata
);
  import hcr_pkg::*;

  logic [CC_W-1:0]    channel_count_r;
  logic [RATIO_W-1:0] rate_ratio_r;
  cmd_t               cmd;
  status_t            status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= CC_W'(2);
      rate_ratio_r    <= RATIO_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index) begin
        rate_ratio_r <= cfg_wdata;
      end else begin
        channel_count_r <= cfg_wdata[CC_W-1:0];
      end
    end
  end

  hcr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd)
  );

  hcr_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_operation   (in_operation),
    .in_sample      (in_sample),
    .channel_count  (channel_count_r),
    .rate_ratio_q16 (rate_ratio_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_block_last (out_block_last)
  );

endmodule

@@ rtl/hcr_ram.sv @@
// ----------------------------------------------------------------------------
// hcr_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module hcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcr_ctrl
// sequencer for one word: total, division, four reads, cubic, result
// ----------------------------------------------------------------------------
module hcr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_operation,
  input  hcr_pkg::status_t status,
  output hcr_pkg::cmd_t    cmd
);
  import hcr_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE:  if (accept && in_operation == OP_PULL) state_nxt = S_TOT;
      S_TOT:   state_nxt = S_LATCH;
      S_LATCH: state_nxt = S_CHK;
      S_CHK: begin
        cnt_nxt   = '0;
        state_nxt = status.empty ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = S_RB;
        end
      end
      S_RB:    state_nxt = S_RA;
      S_RA:    state_nxt = S_RC;
      S_RC:    state_nxt = S_RD;
      S_RD:    state_nxt = S_RW;
      S_RW:    state_nxt = S_K;
      S_K: begin
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_ADD;
      S_ADD: begin
        if (cnt_r == CNT_W'(2)) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_OUT:   if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.accept  = accept;
    cmd.add_sel = cnt_r[1:0];
    case (state_r)
      S_TOT:   cmd.prod_ld = 1'b1;
      S_LATCH: cmd.latch_total = 1'b1;
      S_CHK:   cmd.chk = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_RB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_B;
      end
      S_RA: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_A;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_B;
      end
      S_RC: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_C;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_A;
      end
      S_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_D;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_C;
      end
      S_RW: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_D;
      end
      S_K:     cmd.k_ld = 1'b1;
      S_MUL:   cmd.mul = 1'b1;
      S_ADD:   cmd.add = 1'b1;
      S_OUT:   cmd.out_ld = status.out_free;
      default: ;
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> status.out_free) else $error("result written while output busy");

  a_three_adds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && cnt_r == CNT_W'(2)) |=> state_r == S_OUT)
    else $error("cubic did not finish after three steps");

  a_pull_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_PULL) |=> state_r == S_TOT)
    else $error("pull did not start a computation");

endmodule

@@ rtl/hcr_datapath.sv @@
// ----------------------------------------------------------------------------
// hcr_datapath
// sample store, counters, position divider, cubic evaluation, output register
// ----------------------------------------------------------------------------
module hcr_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hcr_pkg::cmd_t               cmd,
  output hcr_pkg::status_t            status,
  input  logic [1:0]                  in_operation,
  input  logic signed [15:0]          in_sample,
  input  logic [hcr_pkg::CC_W-1:0]    channel_count,
  input  logic [hcr_pkg::RATIO_W-1:0] rate_ratio_q16,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_sample,
  output logic                        out_block_last
);
  import hcr_pkg::*;

  logic [FRAME_W-1:0]  load_frame_r;
  logic [CH_W-1:0]     load_channel_r;
  logic [TOT_W-1:0]    total_r;
  logic [TOT_W-1:0]    index_r;
  logic [CH_W-1:0]     out_channel_r;
  logic                known_r;
  logic [FRAME_W+RATIO_W-1:0] prod_r;
  logic                zero_r;
  logic [DIV_W-1:0]    dvd_r;
  logic [TOT_W-1:0]    rem_r;
  logic                rzero_r;
  logic signed [15:0]  sa_r, sb_r, sc_r, sd_r;
  logic signed [19:0]  k1_r, k2_r, k3_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W+16:0] mprod_r;
  logic                out_valid_r;
  logic signed [15:0]  out_sample_r;
  logic                out_last_r;

  logic [CC_W-1:0]     cc;
  logic [19:0]         load_addr;
  logic                load_ok;
  logic [FRAME_W+RATIO_W:0] tot_sum;
  logic [RATIO_W-1:0]  tot_full;
  logic [TOT_W:0]      trial;
  logic                ge;
  logic [FRAME_W-1:0]  b_raw, b;
  logic [15:0]         t;
  logic [FRAME_W:0]    nb;
  logic [20:0]         raddr_full;
  logic signed [15:0]  rdata, rval;
  logic                a_ok, c_ok, d_ok;
  logic signed [19:0]  ea, eb, ec, ed;
  logic signed [ACC_W-1:0] shifted, addend;
  logic signed [ACC_W-1:0] rnd;
  logic signed [15:0]  sat;
  logic                ch_wrap;

  always_comb begin
    if (channel_count == '0) begin
      cc = CC_W'(1);
    end else if (channel_count > CC_W'(MAX_CHANNELS)) begin
      cc = CC_W'(MAX_CHANNELS);
    end else begin
      cc = channel_count;
    end
  end

  assign load_addr = 20'(load_frame_r) * 20'(cc) + 20'(load_channel_r);
  assign load_ok   = cmd.accept && in_operation == OP_LOAD && !known_r &&
                     load_addr < 20'(STORE_DEPTH);

  assign tot_sum  = (FRAME_W+RATIO_W+1)'(prod_r) + (FRAME_W+RATIO_W+1)'(16'hFFFF);
  assign tot_full = tot_sum[FRAME_W+RATIO_W:16];

  assign status.empty    = (index_r >= total_r) || (load_frame_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;

  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, total_r};

  assign b_raw = dvd_r[16+FRAME_W-1:16];
  assign t     = dvd_r[15:0];
  assign b     = (b_raw >= load_frame_r) ? load_frame_r - 1'b1 : b_raw;
  assign a_ok  = b != '0;
  assign c_ok  = ({1'b0, b} + 1'b1) < {1'b0, load_frame_r};
  assign d_ok  = ({1'b0, b} + 2'd2) < {1'b0, load_frame_r};

  always_comb begin
    case (cmd.rd_sel)
      SEL_A:   nb = {1'b0, b} - 1'b1;
      SEL_C:   nb = {1'b0, b} + 1'b1;
      SEL_D:   nb = {1'b0, b} + 2'd2;
      default: nb = {1'b0, b};
    endcase
  end

  assign raddr_full = 21'(nb) * 21'(cc) + 21'(out_channel_r);
  assign rval       = rzero_r ? 16'sd0 : rdata;

  hcr_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_addr[ADDR_W-1:0]),
    .wdata (in_sample),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign ea = 20'(sa_r);
  assign eb = 20'(sb_r);
  assign ec = 20'(sc_r);
  assign ed = 20'(sd_r);

  assign shifted = ACC_W'(mprod_r >>> 16);
  always_comb begin
    case (cmd.add_sel)
      2'd0:    addend = ACC_W'(k2_r) <<< 16;
      2'd1:    addend = ACC_W'(k1_r) <<< 16;
      default: addend = ACC_W'(eb + eb) <<< 16;
    endcase
  end

  assign rnd = (acc_r + ACC_W'(65536)) >>> 17;
  always_comb begin
    if (rnd > ACC_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (rnd < -ACC_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = rnd[15:0];
    end
  end

  assign ch_wrap = ({1'b0, out_channel_r} + 1'b1) >= cc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_frame_r   <= '0;
      load_channel_r <= '0;
      total_r        <= '0;
      index_r        <= '0;
      out_channel_r  <= '0;
      known_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.accept && in_operation == OP_CLEAR) begin
        load_frame_r   <= '0;
        load_channel_r <= '0;
        total_r        <= '0;
        index_r        <= '0;
        out_channel_r  <= '0;
        known_r        <= 1'b0;
      end
      if (load_ok) begin
        if (({1'b0, load_channel_r} + 1'b1) >= cc) begin
          load_channel_r <= '0;
          load_frame_r   <= load_frame_r + 1'b1;
        end else begin
          load_channel_r <= load_channel_r + 1'b1;
        end
      end
      if (cmd.latch_total && !known_r) begin
        total_r <= (tot_full > RATIO_W'(TOTAL_MAX)) ? TOTAL_MAX : tot_full[TOT_W-1:0];
        known_r <= 1'b1;
      end
      if (cmd.out_ld && !zero_r) begin
        if (ch_wrap) begin
          out_channel_r <= '0;
          index_r       <= index_r + 1'b1;
        end else begin
          out_channel_r <= out_channel_r + 1'b1;
        end
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_ld) begin
      prod_r <= (FRAME_W+RATIO_W)'(load_frame_r) * (FRAME_W+RATIO_W)'(rate_ratio_q16);
    end
    if (cmd.chk) begin
      zero_r <= status.empty;
      dvd_r  <= {NUM_W'(index_r) * NUM_W'(load_frame_r), 16'h0000};
      rem_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? TOT_W'(trial - {1'b0, total_r}) : trial[TOT_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], ge};
    end
    if (cmd.rd_en) begin
      rzero_r <= raddr_full >= 21'(STORE_DEPTH);
    end
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        SEL_B:   sb_r <= rval;
        SEL_A:   sa_r <= a_ok ? rval : sb_r;
        SEL_C:   sc_r <= c_ok ? rval : sb_r;
        default: sd_r <= d_ok ? rval : sb_r;
      endcase
    end
    if (cmd.k_ld) begin
      k1_r  <= ec - ea;
      k2_r  <= (ea + ea) - (eb + eb + eb + eb + eb) + (ec + ec + ec + ec) - ed;
      k3_r  <= (eb - ec) + (eb - ec) + (eb - ec) + (ed - ea);
      acc_r <= ACC_W'((eb - ec) + (eb - ec) + (eb - ec) + (ed - ea)) <<< 16;
    end
    if (cmd.mul) begin
      mprod_r <= (ACC_W+17)'(acc_r) * $signed({1'b0, t});
    end
    if (cmd.add) begin
      acc_r <= shifted + addend;
    end
    if (cmd.out_ld) begin
      out_sample_r <= zero_r ? 16'sd0 : sat;
      out_last_r   <= !zero_r && ch_wrap && (({1'b0, index_r} + 1'b1) >= {1'b0, total_r});
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_block_last = out_last_r;

endmodule
